// ===== hdl/sbda_pkg.sv =====
// ----------------------------------------------------------------------------
// sbda_pkg: shared types and constants
// Character codes and the digit summary that the converter hands to the
// character serializer.
// ----------------------------------------------------------------------------
package sbda_pkg;

   // Width of the text length field
   localparam int unsigned LEN_W = 5;

   // ASCII codes
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_MINUS = 8'd45;

   // Summary of one converted value
   typedef struct packed {
      logic             negative;
      logic [LEN_W-1:0] num_digits;
   } digits_type;

endpackage

// ===== hdl/sbda_dabble.sv =====
// ----------------------------------------------------------------------------
// sbda_dabble: iterative binary to BCD converter
// Takes the sign and magnitude of one value, runs one shift-and-add-3 step
// per clock over the magnitude bits, then strips leading zero digits one per
// clock so the most significant digit sits at the top of the BCD word.
// ----------------------------------------------------------------------------
module sbda_dabble #(
   parameter int unsigned VALUE_BITS = 64,
   parameter int unsigned NUM_DIGITS = 20
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [VALUE_BITS-1:0]     value_in,
   output logic                      idle,
   output logic                      done,
   output sbda_pkg::digits_type      info,
   output logic [4*NUM_DIGITS-1:0]   bcd,
   input  logic                      take
);

   localparam int unsigned STEP_W = $clog2(VALUE_BITS + 1);
   localparam int unsigned BCD_W  = 4 * NUM_DIGITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_NORM,
      ST_DONE
   } state_type;

   state_type                    state_ff;
   logic [STEP_W-1:0]            step_ff;
   logic [VALUE_BITS-1:0]        bin_ff;
   logic [BCD_W-1:0]             bcd_ff;
   logic [sbda_pkg::LEN_W-1:0]   ndig_ff;
   logic                         neg_ff;

   logic [BCD_W-1:0]             adj;
   logic [VALUE_BITS-1:0]        mag_in;
   logic                         neg_in;

   // Split the incoming value into sign and unsigned magnitude
   assign neg_in = value_in[VALUE_BITS-1];
   assign mag_in = neg_in ? (~value_in + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : value_in;

   // Add 3 to every digit of 5 or more ahead of the shift
   always_comb begin
      adj = bcd_ff;
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end
      end
   end

   // Sequencer and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  bin_ff   <= mag_in;
                  bcd_ff   <= '0;
                  neg_ff   <= neg_in;
                  step_ff  <= VALUE_BITS[STEP_W-1:0];
                  ndig_ff  <= NUM_DIGITS[sbda_pkg::LEN_W-1:0];
                  state_ff <= ST_SHIFT;
               end
            end
            ST_SHIFT: begin
               bcd_ff  <= {adj[BCD_W-2:0], bin_ff[VALUE_BITS-1]};
               bin_ff  <= {bin_ff[VALUE_BITS-2:0], 1'b0};
               step_ff <= step_ff - {{(STEP_W-1){1'b0}}, 1'b1};
               if (step_ff == {{(STEP_W-1){1'b0}}, 1'b1}) begin
                  state_ff <= ST_NORM;
               end
            end
            ST_NORM: begin
               // Drop one leading zero digit, keep at least one digit
               if (bcd_ff[BCD_W-1 -: 4] == 4'd0 &&
                   ndig_ff != {{(sbda_pkg::LEN_W-1){1'b0}}, 1'b1}) begin
                  bcd_ff  <= {bcd_ff[BCD_W-5:0], 4'd0};
                  ndig_ff <= ndig_ff - {{(sbda_pkg::LEN_W-1){1'b0}}, 1'b1};
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (take) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign idle            = (state_ff == ST_IDLE);
   assign done            = (state_ff == ST_DONE);
   assign info.negative   = neg_ff;
   assign info.num_digits = ndig_ff;
   assign bcd             = bcd_ff;

endmodule

// ===== hdl/sbda_emit.sv =====
// ----------------------------------------------------------------------------
// sbda_emit: character serializer
// Loads a normalized BCD word and sends the sign and digits as ASCII, most
// significant first, through an output register.
// ----------------------------------------------------------------------------
module sbda_emit #(
   parameter int unsigned NUM_DIGITS = 20
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  sbda_pkg::digits_type         info,
   input  logic [4*NUM_DIGITS-1:0]      bcd,
   output logic                         ready,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [7:0]                   out_char,
   output logic                         out_last,
   output logic [sbda_pkg::LEN_W-1:0]   out_len
);

   localparam int unsigned BCD_W = 4 * NUM_DIGITS;

   logic                         valid_ff, valid_in;
   logic [sbda_pkg::LEN_W-1:0]   rem_ff, rem_in;
   logic                         sign_ff, sign_in;
   logic [BCD_W-1:0]             bcd_ff, bcd_in;
   logic [sbda_pkg::LEN_W-1:0]   len_ff, len_in;
   logic [7:0]                   char_ff, char_in;
   logic                         last_ff, last_in;
   logic [sbda_pkg::LEN_W-1:0]   olen_ff, olen_in;
   logic                         advance;
   logic [sbda_pkg::LEN_W-1:0]   total;

   assign ready   = (rem_ff == '0);
   assign advance = !ready && (!valid_ff || out_ready);
   assign total   = info.num_digits + {{(sbda_pkg::LEN_W-1){1'b0}}, info.negative};

   // Next character: sign first, then digits from the top of the word
   always_comb begin
      valid_in = valid_ff;
      rem_in   = rem_ff;
      sign_in  = sign_ff;
      bcd_in   = bcd_ff;
      len_in   = len_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      olen_in  = olen_ff;
      if (out_ready) begin
         valid_in = 1'b0;
      end
      if (load && ready) begin
         rem_in  = total;
         sign_in = info.negative;
         bcd_in  = bcd;
         len_in  = total;
      end
      if (advance) begin
         valid_in = 1'b1;
         rem_in   = rem_ff - {{(sbda_pkg::LEN_W-1){1'b0}}, 1'b1};
         last_in  = (rem_ff == {{(sbda_pkg::LEN_W-1){1'b0}}, 1'b1});
         olen_in  = len_ff;
         if (sign_ff) begin
            char_in = sbda_pkg::CHAR_MINUS;
            sign_in = 1'b0;
         end else begin
            char_in = sbda_pkg::CHAR_ZERO + {4'd0, bcd_ff[BCD_W-1 -: 4]};
            bcd_in  = {bcd_ff[BCD_W-5:0], 4'd0};
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rem_ff   <= '0;
         sign_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         rem_ff   <= rem_in;
         sign_ff  <= sign_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      bcd_ff  <= bcd_in;
      len_ff  <= len_in;
      char_ff <= char_in;
      last_ff <= last_in;
      olen_ff <= olen_in;
   end

   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;
   assign out_len   = olen_ff;

endmodule

// ===== hdl/signed_binary_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii: signed integer to decimal ASCII text
// Converts one two's complement value per request into its decimal text,
// one character per response, with total length and a last marker.
// ----------------------------------------------------------------------------
// A request carries a signed value in the low VALUE_BITS bits of req_tdata;
// higher bits are ignored. The block answers with one response per character,
// most significant first: a leading '-' for negative values, then the digits,
// zero giving a single '0'. Every response carries the total text length and
// rsp_tlast marks the final character. Conversion runs one shift-and-add-3
// step per clock through a shared BCD adjust unit, one step per magnitude
// bit, then strips leading zero digits one per cycle (up to NUM_DIGITS-1
// digits, at least one at 64 bits), keeping at least one digit. Characters
// stream out of a separate serializer at one per cycle unless the response
// side stalls, while the converter takes the next request; a finished
// conversion waits until the serializer has moved every character of the
// previous one into its output register.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii #(
   parameter int unsigned VALUE_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] char_code, [12:8] text_length, [15:13] zero
   output logic        rsp_tlast
);

   // Digit capacity, a safe bound on the decimal digits of the magnitude
   localparam int unsigned NUM_DIGITS = (VALUE_BITS * 31) / 100 + 1;

   logic                         conv_idle;
   logic                         conv_done;
   sbda_pkg::digits_type         conv_info;
   logic [4*NUM_DIGITS-1:0]      conv_bcd;
   logic                         emit_ready;
   logic                         handoff;
   logic [7:0]                   char_code;
   logic [sbda_pkg::LEN_W-1:0]   text_length;

   assign req_tready = conv_idle;
   assign handoff    = conv_done && emit_ready;

   sbda_dabble #(
      .VALUE_BITS (VALUE_BITS),
      .NUM_DIGITS (NUM_DIGITS)
   ) u_dabble (
      .clock    (clock),
      .reset    (reset),
      .start    (req_tvalid && conv_idle),
      .value_in (req_tdata[VALUE_BITS-1:0]),
      .idle     (conv_idle),
      .done     (conv_done),
      .info     (conv_info),
      .bcd      (conv_bcd),
      .take     (handoff)
   );

   sbda_emit #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (handoff),
      .info      (conv_info),
      .bcd       (conv_bcd),
      .ready     (emit_ready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (char_code),
      .out_last  (rsp_tlast),
      .out_len   (text_length)
   );

   // Pack the response fields
   assign rsp_tdata = {3'b000, text_length, char_code};

endmodule

// ===== sim/sbda_text_monitor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sbda_text_monitor: response checker for the decimal text converter
// Watches both stream channels. Every accepted request is turned into the
// characters of its decimal text. Every accepted response is compared with
// the oldest character still owed. The mismatch count and the number of
// characters still owed are handed to the testbench top.
// ----------------------------------------------------------------------------
module sbda_text_monitor #(
   parameter int unsigned VALUE_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        rsp_tlast,
   output int          error_count,
   output int          pending_chars
);

   localparam logic [63:0] DEC_RADIX  = 64'd10;
   localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_BITS);
   localparam int          MAX_CHARS  = 20;
   localparam int          MAX_SHOWN  = 10;

   // One character of decimal text with its framing
   typedef struct packed {
      logic [7:0]                 code;
      logic                       last;
      logic [sbda_pkg::LEN_W-1:0] length;
   } text_char_type;

   text_char_type owed_chars[$];

   // Queue the text of one value, sign first, most significant digit next
   function automatic void queue_decimal_text(input logic [63:0] value);
      logic [63:0]   raw;
      logic [63:0]   mag;
      logic          negative;
      logic [7:0]    digits[MAX_CHARS];
      int            num_digits;
      int            total;
      int            pos;
      text_char_type item;
      raw        = value & VALUE_MASK;
      negative   = raw[VALUE_BITS-1];
      mag        = negative ? ((~raw + 64'd1) & VALUE_MASK) : raw;
      num_digits = 0;
      // Peel digits off the low end
      do begin
         digits[num_digits] = sbda_pkg::CHAR_ZERO + 8'(mag % DEC_RADIX);
         num_digits++;
         mag = mag / DEC_RADIX;
      end while (mag != 64'd0);
      total = num_digits + (negative ? 1 : 0);
      pos   = 0;
      if (negative) begin
         item.code   = sbda_pkg::CHAR_MINUS;
         item.last   = (total == 1);
         item.length = total[sbda_pkg::LEN_W-1:0];
         owed_chars.push_back(item);
         pos = 1;
      end
      for (int k = num_digits - 1; k >= 0; k--) begin
         item.code   = digits[k];
         item.last   = (pos == total - 1);
         item.length = total[sbda_pkg::LEN_W-1:0];
         owed_chars.push_back(item);
         pos++;
      end
   endfunction

   // Compare responses first, then add the text of a new request
   always @(posedge clock) begin : watch
      text_char_type want;
      if (reset) begin
         error_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (owed_chars.size() == 0) begin
               if (error_count < MAX_SHOWN)
                  $display("[%0t] unexpected response: tdata=%h tlast=%b",
                           $realtime, rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               want = owed_chars.pop_front();
               if (rsp_tdata[7:0] !== want.code || rsp_tdata[12:8] !== want.length ||
                   rsp_tlast !== want.last || rsp_tdata[15:13] !== 3'b000) begin
                  if (error_count < MAX_SHOWN) begin
                     $display("[%0t] character mismatch: expected code=%0d len=%0d last=%b",
                              $realtime, want.code, want.length, want.last);
                     $display("[%0t]    got code=%0d len=%0d last=%b pad=%b",
                              $realtime, rsp_tdata[7:0], rsp_tdata[12:8], rsp_tlast,
                              rsp_tdata[15:13]);
                  end
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            queue_decimal_text(req_tdata);
      end
      pending_chars = owed_chars.size();
   end

endmodule

// ===== sim/signed_binary_to_decimal_ascii_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_test: testbench for the decimal text converter
// Sends directed edge values (zero, one digit and carry boundaries, the most
// positive and most negative values, alternating bit patterns) and then
// random values weighted toward every text length, with random gaps on the
// request side and random stalls on the response side, plus one long response
// stall that backs the converter up. A separate monitor predicts and checks.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii_test;

   localparam int NUM_RANDOM  = 250;
   localparam int HOLD_AFTER  = 40;
   localparam int HOLD_CYCLES = 600;
   localparam int QUIET_FIRST = 100;
   localparam int QUIET_LAST  = 150;
   localparam int DRAIN_CYCLES = 100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = 64'd0;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;

   logic        rsp_ready_drawn = 1'b0;
   logic        hold_rsp = 1'b0;
   int          sent_count = 0;
   int          error_count;
   int          pending_chars;

   logic [63:0] directed_values[$] = '{
      64'd0, 64'd1, -64'sd1, 64'd9, -64'sd9, 64'd10, -64'sd10, 64'd99, 64'd100,
      64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
      64'd999999999999999999, 64'd1000000000000000000, -64'sd1000000000000000000,
      64'd1234567890123456789, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
      64'h0000_0000_7FFF_FFFF, 64'hFFFF_FFFF_8000_0000, 64'hFFFF_FFFF_FFFF_FFFE
   };

   // Clock: 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   assign rsp_tready = rsp_ready_drawn && !hold_rsp;

   signed_binary_to_decimal_ascii u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   sbda_text_monitor u_monitor (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .error_count   (error_count),
      .pending_chars (pending_chars)
   );

   // Gaps and stalls are switched off for one stretch of requests
   function automatic bit quiet_phase();
      return sent_count >= QUIET_FIRST && sent_count < QUIET_LAST;
   endfunction

   // Random value: full range, a chosen digit count, small, or near an extreme
   function automatic logic [63:0] random_value();
      logic [63:0] low_bound;
      logic [63:0] span;
      logic [63:0] value;
      int          kind;
      int          num_digits;
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
         value = {$urandom, $urandom};
      end else if (kind < 75) begin
         num_digits = $urandom_range(1, 19);
         low_bound  = 64'd1;
         repeat (num_digits - 1) low_bound = low_bound * 64'd10;
         span  = low_bound * 64'd10 - low_bound;
         value = low_bound + ({$urandom, $urandom} % span);
         if ($urandom_range(0, 1) == 1)
            value = -value;
      end else if (kind < 90) begin
         value = 64'($urandom_range(0, 200)) - 64'd100;
      end else begin
         case ($urandom_range(0, 3))
            0:       value = 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 3));
            1:       value = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
            2:       value = 64'hFFFF_FFFF_8000_0000 + 64'($urandom_range(0, 3));
            default: value = 64'h0000_0000_7FFF_FFFF - 64'($urandom_range(0, 3));
         endcase
      end
      return value;
   endfunction

   // Offer one request after a random gap and hold it until accepted
   task automatic send_request(input logic [63:0] value);
      int gap;
      gap = quiet_phase() ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= value;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      sent_count++;
      @(negedge clock);
   endtask

   // Stimulus and verdict
   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (directed_values[i])
         send_request(directed_values[i]);
      repeat (NUM_RANDOM)
         send_request(random_value());
      req_tvalid <= 1'b0;
      while (pending_chars != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && pending_chars == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Response side: random stall before each character
   initial begin : drain_side
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = quiet_phase() ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_ready_drawn <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready_drawn <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   // Long response hold-off so the converter fills and stalls requests
   initial begin
      while (sent_count < HOLD_AFTER) @(negedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold_rsp <= 1'b0;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
